### sv/pvw_pkg.sv
// shared types and constants for the xz polygon vertex weld block
package pvw_pkg;

  localparam int FIELD_W    = 32;
  localparam int TDATA_W    = 2 * FIELD_W;
  localparam int TOL_W      = 31;
  localparam int TOL_SQ_W   = 2 * TOL_W;
  localparam logic [TOL_SQ_W-1:0] TOL_SQ_RESET = TOL_SQ_W'(66 * 66);

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
  localparam logic [CNT_W-1:0] ROOM_LIMIT = CNT_W'(FIFO_DEPTH - 2);

  typedef struct packed {
    logic                     last;
    logic signed [FIELD_W-1:0] z;
    logic signed [FIELD_W-1:0] x;
  } pvw_word_t;

endpackage

### sv/polygon_vertex_weld_xz_core.sv
// top level of the xz polygon vertex weld: near-duplicate removal and closing drop
//
// in_*  : one polygon vertex per word, in_tdata = {vertex_z, vertex_x}, in_tlast
//         marks the final vertex of a polygon
// out_* : kept vertices in order, out_tdata = {kept_z, kept_x}, out_tlast marks
//         the final kept vertex of a polygon
// cfg_* : cfg_wen writes the weld tolerance (unsigned Q15.16); its square is
//         registered on the write, so write only while the block is idle
// an accepted word is held in the input register, then the keep and close
// decisions update the polygon state and push zero to two words into a
// four-entry output queue, which drives out_tdata and out_tlast directly
// throughput is one input word per cycle while the queue has room; in_tready
// drops while a word waits in the input register and the queue holds three or
// more words, so a stalled receiver backs up into the input after at most four
// queued words; a word that closes a polygon can give two results, so sustained
// rate is then limited by one output word per cycle
// a close that yields three vertices sends the third with the next input word
// reset clears the polygon state, the queue and the input register and sets
// the tolerance to 66
module polygon_vertex_weld_xz_core
  import pvw_pkg::*;
#(
  parameter int COORD_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [TDATA_W-1:0] in_tdata,   // vertex_x, vertex_z
  input  logic               in_tlast,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [TDATA_W-1:0] out_tdata,  // kept_x, kept_z
  output logic               out_tlast,
  input  logic               cfg_wen,
  input  logic [TOL_W-1:0]   cfg_wdata
);

  localparam int CW    = COORD_WIDTH;
  localparam int SUM_W = 2 * CW + 3;
  localparam int CMP_W = (SUM_W > TOL_SQ_W) ? SUM_W : TOL_SQ_W;

  function automatic logic within_tol(
    input logic signed [CW-1:0]       ax,
    input logic signed [CW-1:0]       az,
    input logic signed [CW-1:0]       bx,
    input logic signed [CW-1:0]       bz,
    input logic [TOL_SQ_W-1:0]        tsq
  );
    logic signed [CW:0]  dx;
    logic signed [CW:0]  dz;
    logic [CW:0]         ux;
    logic [CW:0]         uz;
    logic [SUM_W-1:0]    sum;
    dx  = {ax[CW-1], ax} - {bx[CW-1], bx};
    dz  = {az[CW-1], az} - {bz[CW-1], bz};
    ux  = dx[CW] ? (CW+1)'(-dx) : (CW+1)'(dx);
    uz  = dz[CW] ? (CW+1)'(-dz) : (CW+1)'(dz);
    sum = SUM_W'(ux) * SUM_W'(ux) + SUM_W'(uz) * SUM_W'(uz);
    return CMP_W'(sum) <= CMP_W'(tsq);
  endfunction

  // tolerance square
  logic [TOL_SQ_W-1:0] tolsq_r;
  logic [TOL_SQ_W-1:0] tol_ext;
  assign tol_ext = TOL_SQ_W'(cfg_wdata);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tolsq_r <= TOL_SQ_RESET;
    end else if (cfg_wen) begin
      tolsq_r <= tol_ext * tol_ext;
    end
  end

  // input register
  logic                 s1_v_r;
  logic signed [CW-1:0] s1_x_r;
  logic signed [CW-1:0] s1_z_r;
  logic                 s1_end_r;
  logic                 go;

  // polygon state
  logic signed [CW-1:0] first_x_r, first_x_nxt;
  logic signed [CW-1:0] first_z_r, first_z_nxt;
  logic signed [CW-1:0] held_x_r [2];
  logic signed [CW-1:0] held_z_r [2];
  logic signed [CW-1:0] held_x_nxt [2];
  logic signed [CW-1:0] held_z_nxt [2];
  logic [1:0]           held_cnt_r, held_cnt_nxt;
  logic                 kmto_r, kmto_nxt;
  logic                 started_r, started_nxt;
  logic                 spill_v_r, spill_v_nxt;
  logic signed [CW-1:0] spill_x_r, spill_x_nxt;
  logic signed [CW-1:0] spill_z_r, spill_z_nxt;

  // output queue
  pvw_word_t            q_r [FIFO_DEPTH];
  logic [PTR_W-1:0]     wr_ptr_r;
  logic [PTR_W-1:0]     rd_ptr_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 pop;

  // per-word emission slots
  logic [1:0]           n_emit;
  logic signed [CW-1:0] e_x [2];
  logic signed [CW-1:0] e_z [2];
  logic                 e_last [2];
  logic signed [CW-1:0] l_x [3];
  logic signed [CW-1:0] l_z [3];
  logic [1:0]           l_cnt;
  logic                 closing;
  logic                 near_h;
  logic                 near_f;
  logic                 hidx;

  assign go        = s1_v_r && (cnt_r <= ROOM_LIMIT);
  assign in_tready = !s1_v_r || go;
  assign hidx      = (held_cnt_r == 2'd2);
  assign near_h    = within_tol(s1_x_r, s1_z_r, held_x_r[hidx], held_z_r[hidx], tolsq_r);
  assign near_f    = within_tol(s1_x_r, s1_z_r, first_x_r, first_z_r, tolsq_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_tready) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_x_r   <= in_tdata[CW-1:0];
      s1_z_r   <= in_tdata[FIELD_W+CW-1:FIELD_W];
      s1_end_r <= in_tlast;
    end
  end

  always_comb begin
    logic signed [CW-1:0] h0x;
    logic signed [CW-1:0] h0z;
    first_x_nxt   = first_x_r;
    first_z_nxt   = first_z_r;
    held_x_nxt[0] = held_x_r[0];
    held_x_nxt[1] = held_x_r[1];
    held_z_nxt[0] = held_z_r[0];
    held_z_nxt[1] = held_z_r[1];
    held_cnt_nxt  = held_cnt_r;
    kmto_nxt      = kmto_r;
    started_nxt   = started_r;
    spill_v_nxt   = spill_v_r;
    spill_x_nxt   = spill_x_r;
    spill_z_nxt   = spill_z_r;
    n_emit        = 2'd0;
    for (int i = 0; i < 2; i++) begin
      e_x[i]    = '0;
      e_z[i]    = '0;
      e_last[i] = 1'b0;
    end
    for (int i = 0; i < 3; i++) begin
      l_x[i] = s1_x_r;
      l_z[i] = s1_z_r;
    end
    l_cnt   = 2'd0;
    closing = 1'b0;
    h0x     = held_x_r[0];
    h0z     = held_z_r[0];

    if (go) begin
      if (spill_v_r) begin
        e_x[0]      = spill_x_r;
        e_z[0]      = spill_z_r;
        e_last[0]   = 1'b1;
        n_emit      = 2'd1;
        spill_v_nxt = 1'b0;
      end
      if (!started_r) begin
        first_x_nxt   = s1_x_r;
        first_z_nxt   = s1_z_r;
        held_x_nxt[0] = s1_x_r;
        held_z_nxt[0] = s1_z_r;
        held_cnt_nxt  = 2'd1;
        kmto_nxt      = 1'b0;
        started_nxt   = 1'b1;
        if (s1_end_r) begin
          l_cnt   = 2'd1;
          closing = 1'b1;
        end
      end else if (near_h) begin
        if (s1_end_r) begin
          l_x[0]  = held_x_r[0];
          l_z[0]  = held_z_r[0];
          l_cnt   = 2'd1;
          closing = 1'b1;
          if (hidx && !kmto_r) begin
            l_x[1] = held_x_r[1];
            l_z[1] = held_z_r[1];
            l_cnt  = 2'd2;
          end
        end
      end else begin
        kmto_nxt = 1'b1;
        if (!s1_end_r) begin
          if (hidx) begin
            e_x[n_emit[0]]    = held_x_r[0];
            e_z[n_emit[0]]    = held_z_r[0];
            e_last[n_emit[0]] = 1'b0;
            n_emit            = n_emit + 2'd1;
            h0x               = held_x_r[1];
            h0z               = held_z_r[1];
          end
          if (!near_f) begin
            e_x[n_emit[0]]    = h0x;
            e_z[n_emit[0]]    = h0z;
            e_last[n_emit[0]] = 1'b0;
            n_emit            = n_emit + 2'd1;
            held_x_nxt[0]     = s1_x_r;
            held_z_nxt[0]     = s1_z_r;
            held_cnt_nxt      = 2'd1;
          end else begin
            held_x_nxt[0] = h0x;
            held_z_nxt[0] = h0z;
            held_x_nxt[1] = s1_x_r;
            held_z_nxt[1] = s1_z_r;
            held_cnt_nxt  = 2'd2;
          end
        end else begin
          l_x[0]  = held_x_r[0];
          l_z[0]  = held_z_r[0];
          l_cnt   = 2'd1;
          closing = 1'b1;
          if (hidx) begin
            l_x[1] = held_x_r[1];
            l_z[1] = held_z_r[1];
            l_cnt  = 2'd2;
          end
          if (!near_f) begin
            l_x[l_cnt] = s1_x_r;
            l_z[l_cnt] = s1_z_r;
            l_cnt      = l_cnt + 2'd1;
          end
        end
      end

      if (closing) begin
        for (int i = 0; i < 3; i++) begin
          if (2'(i) < l_cnt) begin
            if (n_emit < 2'd2) begin
              e_x[n_emit[0]]    = l_x[i];
              e_z[n_emit[0]]    = l_z[i];
              e_last[n_emit[0]] = (2'(i) == l_cnt - 2'd1);
              n_emit            = n_emit + 2'd1;
            end else begin
              spill_x_nxt = l_x[i];
              spill_z_nxt = l_z[i];
              spill_v_nxt = 1'b1;
            end
          end
        end
        held_cnt_nxt = 2'd0;
        kmto_nxt     = 1'b0;
        started_nxt  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_cnt_r <= 2'd0;
      kmto_r     <= 1'b0;
      started_r  <= 1'b0;
      spill_v_r  <= 1'b0;
      first_x_r  <= '0;
      first_z_r  <= '0;
    end else begin
      held_cnt_r <= held_cnt_nxt;
      kmto_r     <= kmto_nxt;
      started_r  <= started_nxt;
      spill_v_r  <= spill_v_nxt;
      first_x_r  <= first_x_nxt;
      first_z_r  <= first_z_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_x_r[0] <= held_x_nxt[0];
    held_x_r[1] <= held_x_nxt[1];
    held_z_r[0] <= held_z_nxt[0];
    held_z_r[1] <= held_z_nxt[1];
    spill_x_r   <= spill_x_nxt;
    spill_z_r   <= spill_z_nxt;
  end

  // output queue
  assign out_tvalid = (cnt_r != '0);
  assign pop        = out_tvalid && out_tready;
  assign out_tdata  = {q_r[rd_ptr_r].z, q_r[rd_ptr_r].x};
  assign out_tlast  = q_r[rd_ptr_r].last;

  always_ff @(posedge clk) begin
    if (n_emit != 2'd0) begin
      q_r[wr_ptr_r] <= '{last: e_last[0], z: FIELD_W'(e_z[0]), x: FIELD_W'(e_x[0])};
    end
    if (n_emit == 2'd2) begin
      q_r[wr_ptr_r + PTR_W'(1)] <=
        '{last: e_last[1], z: FIELD_W'(e_z[1]), x: FIELD_W'(e_x[1])};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + PTR_W'(n_emit);
      rd_ptr_r <= rd_ptr_r + PTR_W'(pop);
      cnt_r    <= cnt_r + CNT_W'(n_emit) - CNT_W'(pop);
    end
  end

endmodule

### sv/pvw_checker.sv
// port-level checks for the xz polygon vertex weld core, bound to the top level
module pvw_checker
  import pvw_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_tvalid,
  input logic               in_tready,
  input logic               out_tvalid,
  input logic               out_tready,
  input logic [TDATA_W-1:0] out_tdata,
  input logic               out_tlast
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result word changed while stalled");

  // reset empties the result queue
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // empty queue never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty result queue");

  // a result after an empty queue comes from an accepted word that passed the input register
  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 2))
    else $error("result appeared without a matching input word");

endmodule

bind polygon_vertex_weld_xz_core pvw_checker u_pvw_checker (.*);

### test/testbench.sv
// self-checking testbench for the xz polygon vertex weld core
module testbench;
  import pvw_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [FIELD_W-1:0] COORD_MAX = 32'h7fff_ffff;
  localparam logic [FIELD_W-1:0] COORD_MIN = 32'h8000_0000;
  localparam logic [TOL_W-1:0]   TOL_MAX   = 31'h7fff_ffff;
  localparam int                 STALL_LIMIT = 5000;

  typedef struct packed {
    logic signed [FIELD_W-1:0] z;
    logic signed [FIELD_W-1:0] x;
  } xz_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [TDATA_W-1:0] in_tdata = '0;   // vertex_x, vertex_z
  logic               in_tlast = 1'b0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [TDATA_W-1:0] out_tdata;       // kept_x, kept_z
  logic               out_tlast;
  logic               cfg_wen = 1'b0;
  logic [TOL_W-1:0]   cfg_wdata = '0;

  // weld state mirror
  logic [TOL_W-1:0] tol_now = TOL_W'(66);
  xz_t              first_pt = '0;
  xz_t              held_pts [2];
  int               held_cnt = 0;
  bit               kept_multi = 1'b0;
  bit               poly_open = 1'b0;
  bit               spill_pending = 1'b0;
  xz_t              spill_pt = '0;

  pvw_word_t kept_q[$];
  int        mismatch_count = 0;
  int        idle_cycles = 0;
  bit        tx_idle_on = 1'b1;
  bit        rx_idle_on = 1'b1;
  int        rx_hold_cycles = 0;
  int        rx_gap = 0;

  polygon_vertex_weld_xz_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic bit near_pt(xz_t a, xz_t b);
    logic [FIELD_W:0]     dx, dz;
    logic [2*FIELD_W+1:0] dist_sq, tol_sq;
    dx = {a.x[FIELD_W-1], a.x} - {b.x[FIELD_W-1], b.x};
    dz = {a.z[FIELD_W-1], a.z} - {b.z[FIELD_W-1], b.z};
    if (dx[FIELD_W]) dx = ~dx + 1'b1;
    if (dz[FIELD_W]) dz = ~dz + 1'b1;
    dist_sq = (2*FIELD_W+2)'(dx) * (2*FIELD_W+2)'(dx) + (2*FIELD_W+2)'(dz) * (2*FIELD_W+2)'(dz);
    tol_sq = (2*FIELD_W+2)'(tol_now) * (2*FIELD_W+2)'(tol_now);
    return dist_sq <= tol_sq;
  endfunction

  function automatic void queue_word(bit last, xz_t p);
    kept_q.insert(kept_q.size(), pvw_word_t'({last, p}));
  endfunction

  task automatic weld_predict(xz_t p, bit end_mark);
    xz_t closing [3];
    int  n_close;
    int  n_out;
    int  i;
    bit  far;
    n_close = 0;
    n_out = 0;
    if (spill_pending) begin
      queue_word(1'b1, spill_pt);
      spill_pending = 1'b0;
      n_out++;
    end
    if (!poly_open) begin
      first_pt = p;
      held_pts[0] = p;
      held_cnt = 1;
      kept_multi = 1'b0;
      poly_open = 1'b1;
      if (!end_mark) return;
      closing[n_close++] = p;
    end else if (near_pt(p, held_pts[held_cnt-1])) begin
      if (!end_mark) return;
      closing[n_close++] = held_pts[0];
      if (held_cnt == 2 && !kept_multi) closing[n_close++] = held_pts[1];
    end else begin
      far = !near_pt(p, first_pt);
      kept_multi = 1'b1;
      if (!end_mark) begin
        if (held_cnt == 2) begin
          queue_word(1'b0, held_pts[0]);
          held_pts[0] = held_pts[1];
          held_cnt = 1;
        end
        if (far) begin
          queue_word(1'b0, held_pts[0]);
          held_pts[0] = p;
          held_cnt = 1;
        end else begin
          held_pts[1] = p;
          held_cnt = 2;
        end
        return;
      end
      for (i = 0; i < held_cnt; i++) closing[n_close++] = held_pts[i];
      if (far) closing[n_close++] = p;
    end
    // at most two words per vertex, a third closing word waits for the next vertex
    for (i = 0; i < n_close; i++) begin
      if (n_out < 2) begin
        queue_word(i == n_close - 1, closing[i]);
        n_out++;
      end else begin
        spill_pt = closing[i];
        spill_pending = 1'b1;
      end
    end
    held_cnt = 0;
    kept_multi = 1'b0;
    poly_open = 1'b0;
  endtask

  function automatic int pick_gap();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(12, 60);
  endfunction

  task automatic send_vertex(logic [FIELD_W-1:0] x, logic [FIELD_W-1:0] z, bit end_mark);
    int  gap;
    xz_t p;
    gap = (tx_idle_on && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
    p.x = x;
    p.z = z;
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= p;
    in_tlast  <= end_mark;
    do @(posedge clk); while (!in_tready);
    weld_predict(p, end_mark);
  endtask

  task automatic set_tolerance(logic [TOL_W-1:0] value);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (kept_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_wen <= 1'b0;
    tol_now = value;
  endtask

  function automatic logic [FIELD_W-1:0] rand_offset(longint unsigned span);
    logic [FIELD_W-1:0] mag;
    if (span > 64'h7fff_ffff) span = 64'h7fff_ffff;
    mag = $urandom_range(span[31:0], 0);
    return $urandom_range(0, 1) ? -mag : mag;
  endfunction

  function automatic xz_t gen_vertex(xz_t prev, xz_t first_v, bit closing_vtx);
    int unsigned     r;
    longint unsigned t;
    xz_t             v;
    t = tol_now;
    r = $urandom_range(0, 15);
    if (closing_vtx && $urandom_range(0, 2) == 0) r = 6;
    case (r)
      0, 1: begin
        v.x = $urandom;
        v.z = $urandom;
      end
      2, 3, 4: begin
        v.x = prev.x + rand_offset(t / 2);
        v.z = prev.z + rand_offset(t / 2);
      end
      5: begin
        v.x = prev.x + FIELD_W'(t) + $urandom_range(0, 1);
        v.z = prev.z;
      end
      6, 7: begin
        v.x = first_v.x + rand_offset(t / 2);
        v.z = first_v.z + rand_offset(t / 2);
      end
      8: v = prev;
      default: begin
        v.x = prev.x + rand_offset(t * 4 + 256);
        v.z = prev.z + rand_offset(t * 4 + 256);
      end
    endcase
    return v;
  endfunction

  task automatic send_random_polygons(int n_items);
    int  sent;
    int  len;
    int  i;
    xz_t first_v;
    xz_t v;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 14) : $urandom_range(1, 6);
      for (i = 0; i < len; i++) begin
        if (i == 0) begin
          case ($urandom_range(0, 3))
            0: begin
              v.x = $urandom;
              v.z = $urandom;
            end
            1: begin
              v.x = $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
              v.z = $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
            end
            default: begin
              v.x = rand_offset(64'd1 << 20);
              v.z = rand_offset(64'd1 << 20);
            end
          endcase
          first_v = v;
        end else begin
          v = gen_vertex(v, first_v, i == len - 1);
        end
        send_vertex(v.x, v.z, i == len - 1);
      end
      sent += len;
    end
  endtask

  task automatic test_single_vertex();
    send_vertex(COORD_MIN, COORD_MAX, 1'b1);
    send_vertex(COORD_MAX, COORD_MIN, 1'b1);
  endtask

  task automatic test_weld_keep();
    send_vertex(0, 0, 1'b0);
    send_vertex(66, 0, 1'b0);
    send_vertex(67, 0, 1'b0);
    send_vertex(107, 40, 1'b0);
    send_vertex(1000, 1000, 1'b1);
  endtask

  task automatic test_closing_drop();
    send_vertex(0, 0, 1'b0);
    send_vertex(5000, 0, 1'b0);
    send_vertex(5000, 5000, 1'b0);
    send_vertex(30, 30, 1'b1);
    // held pair, closing vertex welds onto the newest held one
    send_vertex(0, 0, 1'b0);
    send_vertex(5000, 0, 1'b0);
    send_vertex(40, 0, 1'b0);
    send_vertex(45, 0, 1'b1);
  endtask

  task automatic test_three_vertex_close();
    send_vertex(0, 0, 1'b0);
    send_vertex(5000, 0, 1'b0);
    send_vertex(20, 0, 1'b0);
    send_vertex(-5000, -5000, 1'b1);
    send_vertex(7, 7, 1'b1);
  endtask

  task automatic test_tolerance_extremes();
    set_tolerance('0);
    send_vertex(100, 100, 1'b0);
    send_vertex(100, 100, 1'b0);
    send_vertex(101, 100, 1'b1);
    set_tolerance(TOL_MAX);
    send_vertex(COORD_MIN, COORD_MIN, 1'b0);
    send_vertex(COORD_MAX, COORD_MAX, 1'b1);
  endtask

  task automatic test_tolerance_mid_polygon();
    set_tolerance(TOL_W'(1000));
    send_vertex(0, 0, 1'b0);
    send_vertex(800, 0, 1'b0);
    set_tolerance(TOL_W'(500));
    send_vertex(600, 0, 1'b1);
  endtask

  task automatic test_backpressure();
    set_tolerance(TOL_W'(66));
    tx_idle_on = 1'b0;
    rx_hold_cycles = 300;
    send_random_polygons(40);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (kept_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_random_phase(logic [TOL_W-1:0] tol, int n_items, bit tx_idle, bit rx_idle);
    set_tolerance(tol);
    tx_idle_on = tx_idle;
    rx_idle_on = rx_idle;
    send_random_polygons(n_items);
  endtask

  // receiver side
  always @(negedge clk) begin
    if (rx_hold_cycles > 0) begin
      out_tready <= 1'b0;
      rx_hold_cycles--;
    end else if (rx_gap > 0) begin
      out_tready <= 1'b0;
      rx_gap--;
    end else begin
      out_tready <= 1'b1;
      if (rx_idle_on && $urandom_range(0, 3) == 0) rx_gap = pick_gap();
    end
  end

  always @(posedge clk) begin
    pvw_word_t got;
    pvw_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tlast, out_tdata};
      if (kept_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected word: x=%0d z=%0d last=%0b", got.x, got.z, got.last);
      end else begin
        want = kept_q.pop_front();
        if (got.x !== want.x || got.z !== want.z || got.last !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected x=%0d z=%0d last=%0b, got x=%0d z=%0d last=%0b",
                     want.x, want.z, want.last, got.x, got.z, got.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("FAIL polygon_vertex_weld_xz_core");
        $finish;
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_single_vertex();
    test_weld_keep();
    test_closing_drop();
    test_three_vertex_close();
    test_tolerance_extremes();
    test_tolerance_mid_polygon();
    test_backpressure();
    test_random_phase(TOL_W'(66), 200, 1'b1, 1'b1);
    test_random_phase('0, 200, 1'b1, 1'b0);
    test_random_phase(TOL_W'($urandom_range(1, 5000)), 200, 1'b0, 1'b1);
    test_random_phase(TOL_MAX, 200, 1'b1, 1'b1);
    test_random_phase(TOL_W'(65536), 200, 1'b0, 1'b0);
    test_random_phase(TOL_W'($urandom_range(0, 32'h7fff_ffff)), 200, 1'b1, 1'b1);
    test_random_phase(TOL_W'(1), 200, 1'b1, 1'b1);

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (kept_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && kept_q.size() == 0) begin
      $display("PASS polygon_vertex_weld_xz_core");
    end else begin
      $display("FAIL polygon_vertex_weld_xz_core");
    end
    $finish;
  end

endmodule
